@@ hdl/tracker_pattern_channel_decoder_defines.svh @@
// Assertion helpers for the pattern decoder
`ifndef TRACKER_PATTERN_CHANNEL_DECODER_DEFINES_SVH
`define TRACKER_PATTERN_CHANNEL_DECODER_DEFINES_SVH
`ifndef SYNTHESIS
`define TPCD_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define TPCD_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TPCD_ASSERT(lbl, clk, rstn, prop, msg)
`define TPCD_ASSERT_RST(lbl, clk, prop, msg)
`endif
`endif

@@ hdl/tpcd_pkg.sv @@
package tpcd_pkg;
    localparam int EFFECT_STACK_DEPTH_DEF = 16;
    localparam int SAMPLE_COUNT_DEF = 32;

    typedef enum logic [4:0] {
        EV_NOENV = 5'd0, EV_ENV = 5'd1, EV_ORN = 5'd2, EV_SMP = 5'd3, EV_NOISE = 5'd4,
        EV_NOTE = 5'd5, EV_REST = 5'd6, EV_VOL = 5'd7, EV_GLIDE = 5'd8,
        EV_NOTEGLIDE = 5'd9, EV_SMPOFF = 5'd10, EV_ORNOFF = 5'd11, EV_VIB = 5'd12,
        EV_ENVSLIDE = 5'd13, EV_TEMPO = 5'd14, EV_ROWEND = 5'd15, EV_OVERFLOW = 5'd16
    } event_t;

    typedef enum logic [2:0] {
        PH_CMD, PH_ENVHI_SMP, PH_ENVLO_SMP, PH_ENVHI, PH_ENVLO, PH_SMP, PH_PERIOD,
        PH_PARAM
    } phase_t;

    typedef struct packed {
        event_t      ev;
        logic [7:0]  sv;
        logic [15:0] wv;
        logic [15:0] st;
    } result_t;

    // controller -> datapath
    typedef struct packed {
        logic load;   // process latched byte
        logic pop;    // scan one stack entry
        logic take;   // queue head moved to the output register
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic    busy;    // pop scan in progress
        logic    emit;    // a result is presented
        logic    emit_last;
        result_t res;
    } dp_stat_t;

    function automatic logic has_params(input logic [3:0] c);
        return (c >= 4'd1 && c <= 4'd5) || c == 4'd8 || c == 4'd9;
    endfunction
endpackage

@@ hdl/tpcd_datapath.sv @@
module tpcd_datapath
    import tpcd_pkg::*;
#(
    parameter int EFFECT_STACK_DEPTH = EFFECT_STACK_DEPTH_DEF,
    parameter int SAMPLE_COUNT = SAMPLE_COUNT_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  dp_cmd_t    cmd,
    input  logic [7:0] byte_in,
    output dp_stat_t   stat
);
    localparam int AW = (EFFECT_STACK_DEPTH > 1) ? $clog2(EFFECT_STACK_DEPTH) : 1;
    localparam int CW = $clog2(EFFECT_STACK_DEPTH + 1);
    localparam logic [8:0] SMP_LIM = 9'(2 * SAMPLE_COUNT);
    localparam logic [CW-1:0] DEPTH_C = CW'(EFFECT_STACK_DEPTH);

    logic [3:0] stack_mem [EFFECT_STACK_DEPTH];
    logic [3:0] top_reg;  // registered read of top entry

    phase_t      phase_reg, phase_next;
    logic [CW-1:0] count_reg, count_next;
    logic [2:0]  idx_reg, idx_next;
    logic [7:0]  per_reg, per_next, row_reg, row_next, note_reg, note_next;
    logic        held_reg, held_next;
    logic [15:0] w1_reg, w1_next, w2_reg, w2_next;
    logic        busy_reg, busy_next;
    // up to three results queued: shift out one per cycle while the output register is free
    result_t     q_reg [3];
    result_t     q_next [3];
    logic [1:0]  qn_reg, qn_next;
    logic        push_en;
    logic [AW-1:0] push_addr, rd_addr;
    logic [CW-1:0] rd_cnt;

    always_comb begin
        rd_cnt = count_next - CW'(1);
        rd_addr = AW'(rd_cnt);
        push_addr = AW'(count_reg);
    end

    always_ff @(posedge aclk) begin
        if (push_en) stack_mem[push_addr] <= byte_in[3:0];
        top_reg <= (push_en && push_addr == rd_addr) ? byte_in[3:0] : stack_mem[rd_addr];
    end

    always_comb begin
        result_t r;
        logic finish, done;
        logic [15:0] w1v, w2v;
        phase_next = phase_reg; count_next = count_reg; idx_next = idx_reg;
        per_next = per_reg; row_next = row_reg; note_next = note_reg;
        held_next = held_reg; w1_next = w1_reg; w2_next = w2_reg;
        busy_next = 1'b0; push_en = 1'b0; finish = 1'b0; done = 1'b0;
        q_next = q_reg;
        qn_next = qn_reg;
        r = '0;
        w1v = w1_reg; w2v = w2_reg;
        if (cmd.pop) begin
            // top_reg holds entry count_reg-1
            if (count_reg == '0) finish = 1'b1;
            else if (has_params(top_reg)) begin
                phase_next = PH_PARAM; idx_next = '0;
            end else begin
                count_next = count_reg - CW'(1); busy_next = 1'b1;
            end
        end else if (cmd.load) begin
            unique case (phase_reg)
                PH_ENVHI_SMP, PH_ENVHI: begin
                    w1_next = {byte_in, 8'h00};
                    phase_next = (phase_reg == PH_ENVHI_SMP) ? PH_ENVLO_SMP : PH_ENVLO;
                end
                PH_ENVLO_SMP, PH_ENVLO: begin
                    w1_next = {w1_reg[15:8], byte_in};
                    r.ev = EV_ENV; r.sv = per_reg; r.wv = w1_next;
                    q_next[0] = r; qn_next = 2'd1;
                    phase_next = (phase_reg == PH_ENVLO_SMP) ? PH_SMP : PH_CMD;
                end
                PH_SMP: begin
                    r.ev = EV_SMP;
                    r.sv = ({1'b0, byte_in} < SMP_LIM && !byte_in[0]) ?
                           {1'b0, byte_in[7:1]} : 8'd0;
                    q_next[0] = r; qn_next = 2'd1; phase_next = PH_CMD;
                end
                PH_PERIOD: begin
                    row_next = byte_in - 8'd1; phase_next = PH_CMD;
                end
                PH_PARAM: begin
                    if (count_reg == '0) finish = 1'b1;
                    else begin
                        if (idx_reg == 3'd0) per_next = byte_in;
                        else if (idx_reg == 3'd1) w1v = {8'h00, byte_in};
                        else if (idx_reg == 3'd2) w1v = {byte_in, w1_reg[7:0]};
                        else if (idx_reg == 3'd3) w2v = {8'h00, byte_in};
                        else w2v = {byte_in, w2_reg[7:0]};
                        w1_next = w1v; w2_next = w2v;
                        case (top_reg)
                            4'd1: if (idx_reg == 3'd2) begin
                                r.ev = EV_GLIDE; r.sv = per_reg; r.st = w1v; done = 1'b1;
                            end
                            4'd2: if (idx_reg == 3'd4) begin
                                r.ev = EV_NOTEGLIDE; r.sv = per_reg; r.wv = w1v;
                                r.st = w2v; done = 1'b1;
                            end
                            4'd3: begin r.ev = EV_SMPOFF; r.sv = byte_in; done = 1'b1; end
                            4'd4: begin r.ev = EV_ORNOFF; r.sv = byte_in; done = 1'b1; end
                            4'd5: if (idx_reg == 3'd1) begin
                                r.ev = EV_VIB; r.sv = per_reg; r.wv = {8'h00, byte_in};
                                done = 1'b1;
                            end
                            4'd8: if (idx_reg == 3'd2) begin
                                r.ev = EV_ENVSLIDE; r.sv = per_reg; r.st = w1v; done = 1'b1;
                            end
                            4'd9: begin r.ev = EV_TEMPO; r.sv = byte_in; done = 1'b1; end
                            default: done = 1'b1;
                        endcase
                        if (done) begin
                            if (top_reg == 4'd0 || top_reg == 4'd6 || top_reg == 4'd7 ||
                                top_reg >= 4'd10) qn_next = 2'd0;
                            else begin q_next[0] = r; qn_next = 2'd1; end
                            count_next = count_reg - CW'(1); idx_next = '0;
                            busy_next = 1'b1;
                        end else idx_next = idx_reg + 3'd1;
                    end
                end
                default: begin
                    phase_next = PH_CMD;
                    if (byte_in < 8'h10) begin
                        if (count_reg >= DEPTH_C) begin
                            r.ev = EV_OVERFLOW; r.sv = byte_in; q_next[0] = r; qn_next = 2'd1;
                        end else begin
                            push_en = 1'b1; count_next = count_reg + CW'(1);
                        end
                    end else if (byte_in == 8'h10) begin
                        r.ev = EV_NOENV; q_next[0] = r; qn_next = 2'd1; phase_next = PH_SMP;
                    end else if (byte_in < 8'h20) begin
                        per_next = byte_in - 8'h10; phase_next = PH_ENVHI_SMP;
                    end else if (byte_in >= 8'hB2 && byte_in <= 8'hBF) begin
                        per_next = byte_in - 8'hB1; phase_next = PH_ENVHI;
                    end else if (byte_in >= 8'hF0) begin
                        r.ev = EV_NOENV; q_next[0] = r;
                        r.ev = EV_ORN; r.sv = byte_in - 8'hF0; q_next[1] = r;
                        qn_next = 2'd2; phase_next = PH_SMP;
                    end else if (byte_in < 8'h40) begin
                        r.ev = EV_NOISE; r.sv = byte_in - 8'h20; q_next[0] = r; qn_next = 2'd1;
                    end else if (byte_in < 8'h50) begin
                        r.ev = EV_ORN; r.sv = byte_in - 8'h40; q_next[0] = r; qn_next = 2'd1;
                    end else if (byte_in < 8'hB0) begin
                        note_next = byte_in - 8'h50; held_next = 1'b1; busy_next = 1'b1;
                    end else if (byte_in == 8'hB0) begin
                        r.ev = EV_NOENV; q_next[0] = r; qn_next = 2'd1;
                    end else if (byte_in == 8'hB1) begin
                        phase_next = PH_PERIOD;
                    end else if (byte_in == 8'hC0) begin
                        r.ev = EV_REST; q_next[0] = r; qn_next = 2'd1; busy_next = 1'b1;
                    end else if (byte_in < 8'hD0) begin
                        r.ev = EV_VOL; r.sv = byte_in - 8'hC0; q_next[0] = r; qn_next = 2'd1;
                    end else if (byte_in == 8'hD0) begin
                        busy_next = 1'b1;
                    end else begin
                        r.ev = EV_SMP; r.sv = byte_in - 8'hD0; q_next[0] = r; qn_next = 2'd1;
                    end
                end
            endcase
        end else if (cmd.take) begin
            q_next[0] = q_reg[1]; q_next[1] = q_reg[2]; qn_next = qn_reg - 2'd1;
        end
        if (finish) begin
            r = '0;
            if (held_reg) begin
                r.ev = EV_NOTE; r.sv = note_reg; q_next[qn_reg] = r;
                r.ev = EV_ROWEND; r.sv = row_reg; q_next[qn_reg + 2'd1] = r;
                qn_next = qn_reg + 2'd2;
            end else begin
                r.ev = EV_ROWEND; r.sv = row_reg; q_next[qn_reg] = r;
                qn_next = qn_reg + 2'd1;
            end
            held_next = 1'b0; note_next = '0; idx_next = '0; phase_next = PH_CMD;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_CMD; count_reg <= '0; idx_reg <= '0; per_reg <= '0;
            row_reg <= '0; note_reg <= '0; held_reg <= 1'b0; w1_reg <= '0;
            w2_reg <= '0; busy_reg <= 1'b0; qn_reg <= '0;
        end else begin
            phase_reg <= phase_next; count_reg <= count_next; idx_reg <= idx_next;
            per_reg <= per_next; row_reg <= row_next; note_reg <= note_next;
            held_reg <= held_next; w1_reg <= w1_next; w2_reg <= w2_next;
            busy_reg <= busy_next; qn_reg <= qn_next;
        end
        for (int i = 0; i < 3; i++) q_reg[i] <= q_next[i];
    end

    assign stat.busy = busy_reg;
    assign stat.emit = (qn_reg != '0);
    assign stat.emit_last = (qn_reg == 2'd1);
    assign stat.res = q_reg[0];
endmodule

@@ hdl/tpcd_ctrl.sv @@
`include "tracker_pattern_channel_decoder_defines.svh"
module tpcd_ctrl
    import tpcd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,
    output logic        m_axis_tlast,
    output dp_cmd_t     cmd,
    output logic [7:0]  byte_out,
    input  dp_stat_t    stat
);
    typedef enum logic [1:0] {ST_IDLE, ST_WORK, ST_OUT} state_t;
    state_t state_reg;
    logic [7:0] byte_reg;
    logic [47:0] data_reg;
    logic last_reg, valid_reg;
    logic take;

    // queue head moves into the output register when that register is free
    assign take = (state_reg == ST_OUT) && !stat.busy && stat.emit &&
                  (!valid_reg || m_axis_tready);

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cmd.load = (state_reg == ST_WORK) && !stat.busy;
    // after load, datapath reports busy for scans; keep popping
    assign cmd.pop = (state_reg == ST_OUT) && stat.busy;
    assign cmd.take = take;
    assign byte_out = byte_reg;
    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata = data_reg;
    assign m_axis_tlast = last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end else begin
            if (take) begin
                valid_reg <= 1'b1;
                data_reg <= {3'b000, stat.res.st, stat.res.wv, stat.res.sv, stat.res.ev};
                last_reg <= stat.emit_last;
            end else if (m_axis_tready) begin
                valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: if (s_axis_tvalid) begin
                    byte_reg <= s_axis_tdata;
                    state_reg <= ST_WORK;
                end
                ST_WORK: state_reg <= ST_OUT;
                ST_OUT: if (!stat.busy && !stat.emit) state_reg <= ST_IDLE;
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    `TPCD_ASSERT(a_no_accept_busy, aclk, aresetn, (state_reg != ST_IDLE) |-> !s_axis_tready, "accept while busy")
    `TPCD_ASSERT(a_out_hold, aclk, aresetn, (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid, "output dropped")
    `TPCD_ASSERT(a_no_load_pop, aclk, aresetn, !(cmd.load && cmd.pop), "load and pop together")
endmodule

@@ hdl/tracker_pattern_channel_decoder.sv @@
// channel  dir  handshake                 payload
// s_axis   in   s_axis_tvalid/tready      tdata[7:0] data_byte
// m_axis   out  m_axis_tvalid/tready      tdata: event_res, small_value, wide_value,
//                                         step_value; tlast = last
// After a request is accepted the byte is loaded (ST_WORK); then in ST_OUT each result
// is moved out and, after a row terminator or a completed effect, each stack entry is
// scanned (each parameterless code popped and the final check) before the next accept.
// Reset: aresetn synchronous, active low; clears phase, stack count, held note.
// A stalled result holds the output register and the queue behind it; input waits
// until the queue is empty, so the last result may still wait at the next accept.
module tracker_pattern_channel_decoder
    import tpcd_pkg::*;
#(
    parameter int EFFECT_STACK_DEPTH = EFFECT_STACK_DEPTH_DEF,
    parameter int SAMPLE_COUNT = SAMPLE_COUNT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // event_res[4:0], small_value, wide_value, step_value
    output logic        m_axis_tlast    // last
);
    dp_cmd_t cmd;
    dp_stat_t stat;
    logic [7:0] byte_w;

    tpcd_ctrl u_ctrl (
        .aclk, .aresetn, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
        .cmd, .byte_out(byte_w), .stat
    );

    tpcd_datapath #(
        .EFFECT_STACK_DEPTH(EFFECT_STACK_DEPTH), .SAMPLE_COUNT(SAMPLE_COUNT)
    ) u_dp (
        .aclk, .aresetn, .cmd, .byte_in(byte_w), .stat
    );
endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps

module testbench
    import tpcd_pkg::*;
();

    localparam int STACK_DEPTH = EFFECT_STACK_DEPTH_DEF;
    localparam int NUM_SAMPLES = SAMPLE_COUNT_DEF;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        event_t      ev;
        logic [7:0]  sv;
        logic [15:0] wv;
        logic [15:0] st;
        logic        last;
    } decoded_event_t;

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;
    logic        m_axis_tlast;

    tracker_pattern_channel_decoder dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // decoder mirror state
    phase_t      mir_phase;
    logic [3:0]  mir_codes [STACK_DEPTH];
    int          mir_count;
    int          mir_pidx;
    logic [7:0]  mir_period;
    logic [15:0] mir_word1;
    logic [15:0] mir_word2;
    logic [7:0]  mir_note;
    logic        mir_note_ok;
    logic [7:0]  mir_row_period;

    decoded_event_t expected_events[$];
    decoded_event_t step_events[$];
    int  error_count;
    int  bytes_sent;
    int  events_seen;
    int  cycle_count;
    int  sink_wait;

    function automatic logic code_has_params(logic [3:0] c);
        return (c >= 4'd1 && c <= 4'd5) || c == 4'd8 || c == 4'd9;
    endfunction

    function automatic void add_event(event_t ev, logic [7:0] sv, logic [15:0] wv,
                                      logic [15:0] st);
        decoded_event_t e;
        if (step_events.size() >= 3) return;
        e.ev = ev; e.sv = sv; e.wv = wv; e.st = st; e.last = 1'b0;
        step_events = {step_events, e};
    endfunction

    function automatic void finish_row();
        while (mir_count > 0) begin
            if (code_has_params(mir_codes[mir_count - 1])) begin
                mir_phase = PH_PARAM;
                mir_pidx = 0;
                return;
            end
            mir_count--;
        end
        if (mir_note_ok) add_event(EV_NOTE, mir_note, 16'd0, 16'd0);
        add_event(EV_ROWEND, mir_row_period, 16'd0, 16'd0);
        mir_note_ok = 1'b0;
        mir_note = 8'd0;
        mir_pidx = 0;
        mir_phase = PH_CMD;
    endfunction

    function automatic void decode_command(logic [7:0] c);
        if (c < 8'h10) begin
            if (mir_count >= STACK_DEPTH) add_event(EV_OVERFLOW, c, 16'd0, 16'd0);
            else begin
                mir_codes[mir_count] = c[3:0];
                mir_count++;
            end
        end else if (c == 8'h10) begin
            add_event(EV_NOENV, 8'd0, 16'd0, 16'd0);
            mir_phase = PH_SMP;
        end else if (c < 8'h20) begin
            mir_period = c - 8'h10;
            mir_phase = PH_ENVHI_SMP;
        end else if (c >= 8'hB2 && c <= 8'hBF) begin
            mir_period = c - 8'hB1;
            mir_phase = PH_ENVHI;
        end else if (c >= 8'hF0) begin
            add_event(EV_NOENV, 8'd0, 16'd0, 16'd0);
            add_event(EV_ORN, c - 8'hF0, 16'd0, 16'd0);
            mir_phase = PH_SMP;
        end else if (c < 8'h40) add_event(EV_NOISE, c - 8'h20, 16'd0, 16'd0);
        else if (c < 8'h50) add_event(EV_ORN, c - 8'h40, 16'd0, 16'd0);
        else if (c < 8'hB0) begin
            mir_note = c - 8'h50;
            mir_note_ok = 1'b1;
            finish_row();
        end else if (c == 8'hB0) add_event(EV_NOENV, 8'd0, 16'd0, 16'd0);
        else if (c == 8'hB1) mir_phase = PH_PERIOD;
        else if (c == 8'hC0) begin
            add_event(EV_REST, 8'd0, 16'd0, 16'd0);
            finish_row();
        end else if (c < 8'hD0) add_event(EV_VOL, c - 8'hC0, 16'd0, 16'd0);
        else if (c == 8'hD0) finish_row();
        else add_event(EV_SMP, c - 8'hD0, 16'd0, 16'd0);
    endfunction

    function automatic void decode_effect_param(logic [7:0] b);
        logic [3:0] code;
        int  idx;
        logic done;
        code = mir_codes[mir_count - 1];
        idx = mir_pidx;
        done = 1'b0;
        case (idx)
            0: mir_period = b;
            1: mir_word1 = {8'd0, b};
            2: mir_word1 = mir_word1 | {b, 8'd0};
            3: mir_word2 = {8'd0, b};
            default: mir_word2 = mir_word2 | {b, 8'd0};
        endcase
        case (code)
            4'd1: if (idx == 2) begin
                add_event(EV_GLIDE, mir_period, 16'd0, mir_word1); done = 1'b1;
            end
            4'd2: if (idx == 4) begin
                add_event(EV_NOTEGLIDE, mir_period, mir_word1, mir_word2); done = 1'b1;
            end
            4'd3: begin add_event(EV_SMPOFF, b, 16'd0, 16'd0); done = 1'b1; end
            4'd4: begin add_event(EV_ORNOFF, b, 16'd0, 16'd0); done = 1'b1; end
            4'd5: if (idx == 1) begin
                add_event(EV_VIB, mir_period, {8'd0, b}, 16'd0); done = 1'b1;
            end
            4'd8: if (idx == 2) begin
                add_event(EV_ENVSLIDE, mir_period, 16'd0, mir_word1); done = 1'b1;
            end
            4'd9: begin add_event(EV_TEMPO, b, 16'd0, 16'd0); done = 1'b1; end
            default: done = 1'b1;
        endcase
        if (done) begin
            mir_count--;
            mir_pidx = 0;
            finish_row();
        end else mir_pidx = (idx + 1) & 7;
    endfunction

    function automatic void predict_byte(logic [7:0] b);
        step_events.delete();
        case (mir_phase)
            PH_ENVHI_SMP, PH_ENVHI: begin
                mir_word1 = {b, 8'd0};
                mir_phase = (mir_phase == PH_ENVHI_SMP) ? PH_ENVLO_SMP : PH_ENVLO;
            end
            PH_ENVLO_SMP, PH_ENVLO: begin
                mir_word1 = mir_word1 | {8'd0, b};
                add_event(EV_ENV, mir_period, mir_word1, 16'd0);
                mir_phase = (mir_phase == PH_ENVLO_SMP) ? PH_SMP : PH_CMD;
            end
            PH_SMP: begin
                add_event(EV_SMP, (b < 2 * NUM_SAMPLES && !b[0]) ? b >> 1 : 8'd0,
                          16'd0, 16'd0);
                mir_phase = PH_CMD;
            end
            PH_PERIOD: begin
                mir_row_period = b - 8'd1;
                mir_phase = PH_CMD;
            end
            PH_PARAM: begin
                if (mir_count == 0) finish_row();
                else decode_effect_param(b);
            end
            default: begin
                mir_phase = PH_CMD;
                decode_command(b);
            end
        endcase
        if (step_events.size() > 0) step_events[step_events.size() - 1].last = 1'b1;
        foreach (step_events[i]) expected_events = {expected_events, step_events[i]};
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int idle;
        idle = $urandom_range(0, 10);
        if (idle > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (idle) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        predict_byte(b);
        bytes_sent++;
    endtask

    // result sink with random stalls
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready) begin
                decoded_event_t got;
                decoded_event_t want;
                got.ev = event_t'(m_axis_tdata[4:0]);
                got.sv = m_axis_tdata[12:5];
                got.wv = m_axis_tdata[28:13];
                got.st = m_axis_tdata[44:29];
                got.last = m_axis_tlast;
                events_seen++;
                if (expected_events.size() == 0) begin
                    $error("unexpected result ev=%0d", got.ev);
                    error_count++;
                end else begin
                    want = expected_events.pop_front();
                    if (got.ev !== want.ev) begin
                        $error("event_res exp %0d got %0d", want.ev, got.ev); error_count++;
                    end
                    if (got.sv !== want.sv) begin
                        $error("small_value exp %0d got %0d", want.sv, got.sv); error_count++;
                    end
                    if (got.wv !== want.wv) begin
                        $error("wide_value exp %0d got %0d", want.wv, got.wv); error_count++;
                    end
                    if (got.st !== want.st) begin
                        $error("step_value exp %0d got %0d", $signed(want.st),
                               $signed(got.st));
                        error_count++;
                    end
                    if (got.last !== want.last) begin
                        $error("last exp %0d got %0d", want.last, got.last); error_count++;
                    end
                end
            end
            if (m_axis_tvalid && m_axis_tready) begin
                sink_wait = $urandom_range(0, 10);
                m_axis_tready <= (sink_wait == 0);
            end else if (!m_axis_tready) begin
                if (sink_wait > 0) sink_wait--;
                m_axis_tready <= (sink_wait == 0);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    // byte source helpers for well-formed rows
    function automatic logic [7:0] rand_param_code();
        logic [3:0] pick [7] = '{4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd8, 4'd9};
        return (($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 15))
                                             : {4'd0, pick[$urandom_range(0, 6)]});
    endfunction

    task automatic test_commands();
        send_byte(8'h10); send_byte(8'h00);              // noenv + sample 0
        send_byte(8'h1F); send_byte(8'hFF); send_byte(8'h00); send_byte(8'h3E);
        send_byte(8'hB2); send_byte(8'h00); send_byte(8'hFF);
        send_byte(8'hBF); send_byte(8'h12); send_byte(8'h34);
        send_byte(8'hF0); send_byte(8'h41);              // odd sample byte
        send_byte(8'hFF); send_byte(8'h40);              // out of range sample
        send_byte(8'h20); send_byte(8'h3F); send_byte(8'h4F);
        send_byte(8'hB0); send_byte(8'hC1); send_byte(8'hCF);
        send_byte(8'hD1); send_byte(8'hEF);
        send_byte(8'hB1); send_byte(8'h00);              // row period wraps
        send_byte(8'hC0);                                // rest, row end
    endtask

    task automatic test_effects();
        // every code in order, then note terminator
        for (int c = 0; c < 16; c++) send_byte(8'(c));
        send_byte(8'hAF);
        for (int i = 0; i < 12; i++) send_byte(8'($urandom_range(0, 255)));
        send_byte(8'hFF); send_byte(8'h80); send_byte(8'h7F); send_byte(8'h00);
        send_byte(8'hFF); send_byte(8'h80);
        // stack overflow
        for (int c = 0; c < STACK_DEPTH + 2; c++) send_byte(8'h06);
        send_byte(8'hD0);
        send_byte(8'hB1); send_byte(8'hFF); send_byte(8'h50);
    endtask

    task automatic test_random_rows();
        while (bytes_sent < 150) begin
            if ($urandom_range(0, 7) == 0) send_byte(8'($urandom_range(0, 255)));
            else begin
                repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(8'h11, 8'hEF)));
                repeat ($urandom_range(0, 3)) send_byte(rand_param_code());
                case ($urandom_range(0, 2))
                    0: send_byte(8'($urandom_range(8'h50, 8'hAF)));
                    1: send_byte(8'hC0);
                    default: send_byte(8'hD0);
                endcase
                repeat (12) send_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = 8'd0;
        m_axis_tready = 1'b0;
        error_count = 0; bytes_sent = 0; events_seen = 0; cycle_count = 0;
        sink_wait = 0;
        mir_phase = PH_CMD; mir_count = 0; mir_pidx = 0; mir_period = 0;
        mir_word1 = 0; mir_word2 = 0; mir_note = 0; mir_note_ok = 0; mir_row_period = 0;
        foreach (mir_codes[i]) mir_codes[i] = 4'd0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_commands();
        test_effects();
        test_random_rows();
        s_axis_tvalid <= 1'b0;
        while (expected_events.size() > 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        $display("covered %0d pattern bytes and %0d decoded events", bytes_sent, events_seen);
        $display("commands, effect parameters, overflow and random rows with stalls");
        if (error_count == 0 && expected_events.size() == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end
endmodule

@@ tracker_pattern_channel_decoder.f @@
+incdir+hdl
hdl/tpcd_pkg.sv
hdl/tpcd_datapath.sv
hdl/tpcd_ctrl.sv
hdl/tracker_pattern_channel_decoder.sv
sim/testbench.sv
